// File: hw/rtl/rsm_pkg.sv
// Shared types for the row softmax block: controller states, command and
// status bundles, and the elaboration-time exponent table builder.
`timescale 1ns / 1ps
`default_nettype none
package rsm_pkg;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam int          EXP_W     = 17;
  localparam int          DIV_STEPS = 16;

  typedef enum logic [2:0] {
    S_IN,
    S_RD,
    S_T,
    S_E,
    S_ACC,
    S_DINIT,
    S_DRUN,
    S_OUT
  } state_e;

  typedef struct packed {
    logic wr;
    logic rd;
    logic ld_t;
    logic ld_e;
    logic acc;
    logic sum_clr;
    logic idx_clr;
    logic idx_inc;
    logic div_init;
    logic div_step;
    logic row_clr;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic div_last;
  } sts_t;

  // Ratio whose truncated Q32 power chain of length n stays at or above one half.
  function automatic longint unsigned exp_root(input int n);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned p;
    int i;
    lo = 64'h8000_0000;
    hi = 64'hFFFF_FFFF;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 64'd1) >> 1);
      p = 64'h1_0000_0000;
      for (i = 0; i < n; i++) begin
        p = (p * mid) >> 32;
      end
      if (p >= 64'h8000_0000) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  // Entry k: k-th chain value, rounded to Q1.16.
  function automatic logic [EXP_W-1:0] exp_entry(input longint unsigned r, input int k);
    longint unsigned p;
    int i;
    p = 64'h1_0000_0000;
    for (i = 0; i < k; i++) begin
      p = (p * r) >> 32;
    end
    p = (p + 64'd32768) >> 16;
    return p[EXP_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/rsm_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AW-1:0]            waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [AW-1:0]            raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/rsm_ctrl.sv
// Sequencer for the row softmax block: input phase, exp-and-sum pass,
// divide pass and result handshake. Uses rsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rsm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_tvalid_i,
  input  wire logic          s_tlast_i,
  output logic               s_tready_o,
  output logic               m_tvalid_o,
  input  wire logic          m_tready_i,
  input  wire rsm_pkg::sts_t sts_i,
  output rsm_pkg::cmd_t      cmd_o
);
  rsm_pkg::state_e state_q, state_d;
  logic            pass_q, pass_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsm_pkg::S_IN;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    m_tvalid_o = 1'b0;
    unique case (state_q)
      rsm_pkg::S_IN: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.wr = 1'b1;
          if (s_tlast_i) begin
            cmd_o.sum_clr = 1'b1;
            cmd_o.idx_clr = 1'b1;
            pass_d        = 1'b0;
            state_d       = rsm_pkg::S_RD;
          end
        end
      end
      rsm_pkg::S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = rsm_pkg::S_T;
      end
      rsm_pkg::S_T: begin
        cmd_o.ld_t = 1'b1;
        state_d    = rsm_pkg::S_E;
      end
      rsm_pkg::S_E: begin
        cmd_o.ld_e = 1'b1;
        state_d    = pass_q ? rsm_pkg::S_DINIT : rsm_pkg::S_ACC;
      end
      rsm_pkg::S_ACC: begin
        cmd_o.acc = 1'b1;
        if (sts_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          pass_d        = 1'b1;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
        state_d = rsm_pkg::S_RD;
      end
      rsm_pkg::S_DINIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = rsm_pkg::S_DRUN;
      end
      rsm_pkg::S_DRUN: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = rsm_pkg::S_OUT;
        end
      end
      rsm_pkg::S_OUT: begin
        m_tvalid_o = 1'b1;
        if (m_tready_i) begin
          if (sts_i.idx_last) begin
            cmd_o.row_clr = 1'b1;
            state_d       = rsm_pkg::S_IN;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = rsm_pkg::S_RD;
          end
        end
      end
      default: state_d = rsm_pkg::S_IN;
    endcase
  end
endmodule
`default_nettype wire

// File: hw/rtl/rsm_datapath.sv
// Datapath: row store, running max, exp unit, sum accumulator and
// bit-serial divider. Uses rsm_pkg and rsm_ram.
`timescale 1ns / 1ps
`default_nettype none
module rsm_datapath #(
  parameter int MAX_ROW        = 64,
  parameter int EXP_TABLE_SIZE = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire rsm_pkg::cmd_t cmd_i,
  output rsm_pkg::sts_t      sts_o,
  input  wire logic [15:0]   sample_i,
  output logic [15:0]        prob_o,
  output logic               last_o,
  output logic               ovf_o
);
  localparam int CW  = $clog2(MAX_ROW + 1);
  localparam int AW  = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
  localparam int SW  = $clog2(MAX_ROW * 65536 + 1);
  localparam int TW  = $clog2(EXP_TABLE_SIZE);
  localparam int EW  = rsm_pkg::EXP_W;
  localparam longint unsigned ExpRoot = rsm_pkg::exp_root(EXP_TABLE_SIZE);

  logic [EW-1:0] exp_tbl [EXP_TABLE_SIZE];
  for (genvar g = 0; g < EXP_TABLE_SIZE; g++) begin : g_tbl
    assign exp_tbl[g] = rsm_pkg::exp_entry(ExpRoot, g);
  end

  logic [CW-1:0]       count_q, idx_q;
  logic signed [15:0]  max_q;
  logic                ovf_q;
  logic [32:0]         t_q;
  logic [EW-1:0]       e_q;
  logic [SW-1:0]       sum_q, rem_q;
  logic [15:0]         low_q, quot_q;
  logic [3:0]          dcnt_q;
  logic [15:0]         rdata;
  logic                room;
  logic [15:0]         diff;
  logic [34:0]         kprod;
  logic [TW-1:0]       kidx;
  logic [EW-1:0]       e_d;
  logic [31:0]         dvd;
  logic [SW:0]         trial;
  logic                qbit;

  assign room = count_q < CW'(MAX_ROW);

  rsm_ram #(.WIDTH(16), .DEPTH(MAX_ROW)) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr && room),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (sample_i),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // exp(x - max) = 2^-t, t in Q24
  assign diff  = 16'(max_q - $signed(rdata));
  assign kprod = 35'(t_q[23:0]) * 35'(EXP_TABLE_SIZE);
  assign kidx  = TW'(kprod[34:24]);
  assign e_d   = (t_q[32:24] >= 9'd17) ? '0 : (exp_tbl[kidx] >> t_q[28:24]);

  assign dvd   = {e_q, 15'd0} + 32'(sum_q >> 1);
  assign trial = {rem_q, low_q[15]};
  assign qbit  = trial >= {1'b0, sum_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      max_q   <= 16'sh8000;
      ovf_q   <= 1'b0;
      dcnt_q  <= '0;
    end else begin
      if (cmd_i.row_clr) begin
        count_q <= '0;
        max_q   <= 16'sh8000;
        ovf_q   <= 1'b0;
      end else if (cmd_i.wr) begin
        if (room) begin
          count_q <= count_q + CW'(1);
          if ($signed(sample_i) > max_q) begin
            max_q <= $signed(sample_i);
          end
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.div_init) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_t) begin
      t_q <= {17'd0, diff} * 33'(rsm_pkg::LOG2E_Q16);
    end
    if (cmd_i.ld_e) begin
      e_q <= e_d;
    end
    if (cmd_i.sum_clr) begin
      sum_q <= '0;
    end else if (cmd_i.acc) begin
      sum_q <= sum_q + SW'(e_q);
    end
    if (cmd_i.div_init) begin
      rem_q  <= SW'(dvd[31:16]);
      low_q  <= dvd[15:0];
      quot_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= qbit ? SW'(trial - {1'b0, sum_q}) : SW'(trial);
      low_q  <= {low_q[14:0], 1'b0};
      quot_q <= {quot_q[14:0], qbit};
    end
  end

  assign sts_o.idx_last = idx_q == (count_q - CW'(1));
  assign sts_o.div_last = dcnt_q == 4'(rsm_pkg::DIV_STEPS - 1);
  assign prob_o = quot_q;
  assign last_o = sts_o.idx_last;
  assign ovf_o  = ovf_q;
endmodule
`default_nettype wire

// File: hw/rtl/row_softmax.sv
// Top level of the row softmax block: controller plus datapath.
// Uses rsm_pkg, rsm_ctrl, rsm_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Softmax over one row of signed Q8.8 samples, one word per sample, tlast on
// the last one. Samples are taken one per cycle; up to MAX_ROW are stored and
// later ones are dropped and reported on tuser. After tlast the block runs an
// exp-and-sum pass over the stored samples (store read, log2 scaling
// multiply, table lookup, accumulate), then a divide pass that recomputes each
// exponent and divides it by the sum, one quotient bit per cycle, before the
// output handshake. No input is taken until the last probability of the row
// is accepted.
module row_softmax #(
  parameter int MAX_ROW        = 64,
  parameter int EXP_TABLE_SIZE = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
  input  wire logic        s_axis_tlast,   // row_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] probability
  output logic             m_axis_tlast,   // result_last
  output logic             m_axis_tuser    // [0] overflow
);
  rsm_pkg::cmd_t cmd;
  rsm_pkg::sts_t sts;

  rsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tlast_i  (s_axis_tlast),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rsm_datapath #(
    .MAX_ROW        (MAX_ROW),
    .EXP_TABLE_SIZE (EXP_TABLE_SIZE)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .sample_i (s_axis_tdata),
    .prob_o   (m_axis_tdata),
    .last_o   (m_axis_tlast),
    .ovf_o    (m_axis_tuser)
  );
endmodule
`default_nettype wire

// File: hw/rtl/rsm_checker.sv
// Port-level checks for row_softmax, bound to the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rsm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata <= 16'd32768)
    else $error("probability above one");

  a_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output phases overlap");

  a_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid)
    else $error("block not ready after row end");

  a_mid_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
    else $error("input taken mid-row");
endmodule

bind row_softmax rsm_checker u_rsm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
